@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks, the top level.
// Depends on nothing; take it by include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked a fixed number of cycles later.
`define CHK_DELAY(label, clk, rstn, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ rtl/bfs_pkg.sv @@
// Package for the bilinear frame scaler: sizes, word types and blend helpers.
// Depends on nothing; every RTL module imports it.
package bfs_pkg;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 512;
    localparam int FRAC       = 16;
    localparam int XW         = $clog2(MAX_W);
    localparam int YW         = $clog2(MAX_H);
    localparam int BAW        = (XW - 1) + (YW - 1);
    localparam int BANK_DEPTH = 1 << BAW;
    localparam int STEPW      = 25;
    localparam int DXW        = 11;
    localparam int POSW       = DXW + STEPW;
    localparam int WHW        = POSW - FRAC;
    localparam int ONEW       = FRAC + 1;
    localparam int FIFO_DEPTH = 8;
    localparam int FPW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);
    localparam int INFLIGHT   = 3;

    localparam logic [STEPW-1:0] STEP_RESET = STEPW'(1 << FRAC);
    localparam logic [ONEW-1:0]  ONE        = ONEW'(1 << FRAC);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic REG_X_STEP = 1'b0;
    localparam logic REG_Y_STEP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [8:0]  src_x;
        logic [8:0]  src_y;
        logic [7:0]  ch0_in;
        logic [7:0]  ch1_in;
        logic [7:0]  ch2_in;
        logic [10:0] dest_x;
        logic [10:0] dest_y;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] ch0_out;
        logic [7:0] ch1_out;
        logic [7:0] ch2_out;
    } pix_out_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic                     is_load;
        logic [1:0]               wbank;
        logic [BAW-1:0]           waddr;
        logic [23:0]              wdata;
        logic [3:0][BAW-1:0]      raddr;
        logic                     x1p;
        logic                     x2p;
        logic                     y1p;
        logic                     y2p;
        logic [FRAC-1:0]          fx;
        logic [FRAC-1:0]          fy;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_word_t;

    // (ONE-f)*a + f*b on 8-bit samples; fits in FRAC+8 bits.
    function automatic logic [FRAC+7:0] blend_px(logic [FRAC-1:0] f, logic [7:0] a,
                                                  logic [7:0] b);
        logic [ONEW-1:0]  w0;
        logic [FRAC+8:0]  acc;
        begin
            w0  = ONE - {1'b0, f};
            acc = (FRAC+9)'(w0 * a) + (FRAC+9)'({1'b0, f} * b);
            return acc[FRAC+7:0];
        end
    endfunction

    // (ONE-f)*a + f*b on blended rows, scaled back to one byte.
    function automatic logic [7:0] blend_row(logic [FRAC-1:0] f, logic [FRAC+7:0] a,
                                             logic [FRAC+7:0] b);
        logic [ONEW-1:0]      w0;
        logic [2*FRAC+8:0]    acc;
        begin
            w0  = ONE - {1'b0, f};
            acc = (2*FRAC+9)'(w0 * a) + (2*FRAC+9)'({1'b0, f} * b);
            return acc[2*FRAC +: 8];
        end
    endfunction

endpackage

@@ rtl/bilinear_frame_scaler_top.sv @@
// Bilinear frame scaler top level. One word per clock sustained, loads and queries alike.
// A query's result strobes once it has passed the front pipe (register, multiply, clamp),
// the queue and the back pipe (bank read, row blend, column blend); a load yields no result.
// The receiver cannot stall.
// Reset clears all control state and sets both steps to 1.0; store contents are undefined.
// Depends on bfs_pkg, bfs_front, bfs_fifo, bfs_back and assert_macros.svh.
module bilinear_frame_scaler_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    input  bfs_pkg::pix_in_t   item,
    output logic               busy,
    output logic               valid,
    output bfs_pkg::pix_out_t  result
);
    import bfs_pkg::*;
    `include "assert_macros.svh"

    logic [STEPW-1:0]  x_step_reg, x_step_next;
    logic [STEPW-1:0]  y_step_reg, y_step_next;
    logic              cfg_wr;
    logic              acc;
    logic              acc_query;
    cmd_word_t         push;
    cmd_word_t         head;

    // APB register file: x_step at 0, y_step at 4; other addresses alias by bit 2.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        x_step_next = x_step_reg;
        y_step_next = y_step_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_X_STEP: x_step_next = pwdata[STEPW-1:0];
                REG_Y_STEP: y_step_next = pwdata[STEPW-1:0];
                default:    x_step_next = x_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg <= STEP_RESET;
            y_step_reg <= STEP_RESET;
        end
        else
        begin
            x_step_reg <= x_step_next;
            y_step_reg <= y_step_next;
        end
    end

    // read back the selected step, zero extended
    assign prdata = (paddr[2] == REG_Y_STEP) ? 32'(y_step_reg) : 32'(x_step_reg);

    // accept a word whenever the queue has room for everything in flight
    assign acc       = start && !busy;
    assign acc_query = acc && (item.kind == KIND_QUERY);

    bfs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .item   (item),
        .x_step (x_step_reg),
        .y_step (y_step_reg),
        .push   (push)
    );

    bfs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .head  (head),
        .busy  (busy)
    );

    bfs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .valid  (valid),
        .result (result)
    );

    // every accepted query comes out as a result, and nothing else does
    `CHK_DELAY(a_query_out, clk, rst_n, acc_query, 6, valid, "query lost")
    `CHK_IMPL(a_out_from_query, clk, rst_n, valid, $past(acc_query, 6), "spurious result")
    // the back drains a word each cycle, so the queue never asks to stall
    `CHK_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy, "queue backed up")

endmodule

@@ rtl/bfs_front.sv @@
// Front end: registers accepted words, maps queries to source positions,
// clamps neighbours and builds bank read addresses. Depends on bfs_pkg.
module bfs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  bfs_pkg::pix_in_t         item,
    input  logic [bfs_pkg::STEPW-1:0] x_step,
    input  logic [bfs_pkg::STEPW-1:0] y_step,
    output bfs_pkg::cmd_word_t       push
);
    import bfs_pkg::*;

    logic              a_valid_reg, a_valid_next;
    pix_in_t           a_item_reg;
    logic              b_valid_reg;
    pix_in_t           b_item_reg;
    logic [POSW-1:0]   b_posx_reg, b_posy_reg;
    cmd_word_t         c_word;

    logic [WHW-1:0]    whx, why;
    logic [XW-1:0]     x1, x2;
    logic [YW-1:0]     y1, y2;
    logic [XW-1:0]     colsel [2];
    logic [YW-1:0]     rowsel [2];
    logic              in_range;

    assign a_valid_next = acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_item_reg <= item;
        end
        b_item_reg <= a_item_reg;
        b_posx_reg <= POSW'(a_item_reg.dest_x * x_step);
        b_posy_reg <= POSW'(a_item_reg.dest_y * y_step);
    end

    always_comb
    begin
        whx = b_posx_reg[POSW-1:FRAC];
        why = b_posy_reg[POSW-1:FRAC];
        x1  = (whx > WHW'(MAX_W - 1)) ? XW'(MAX_W - 1) : whx[XW-1:0];
        y1  = (why > WHW'(MAX_H - 1)) ? YW'(MAX_H - 1) : why[YW-1:0];
        x2  = (x1 == XW'(MAX_W - 1)) ? x1 : x1 + XW'(1);
        y2  = (y1 == YW'(MAX_H - 1)) ? y1 : y1 + YW'(1);
        for (int b = 0; b < 2; b++)
        begin
            colsel[b] = (x1[0] == 1'(b)) ? x1 : x2;
            rowsel[b] = (y1[0] == 1'(b)) ? y1 : y2;
        end
        in_range = (32'(b_item_reg.src_x) < 32'(MAX_W)) &&
                   (32'(b_item_reg.src_y) < 32'(MAX_H));

        c_word.cmd.is_load = (b_item_reg.kind == KIND_LOAD);
        c_word.cmd.wbank   = {b_item_reg.src_y[0], b_item_reg.src_x[0]};
        c_word.cmd.waddr   = {b_item_reg.src_y[YW-1:1], b_item_reg.src_x[XW-1:1]};
        c_word.cmd.wdata   = {b_item_reg.ch2_in, b_item_reg.ch1_in, b_item_reg.ch0_in};
        for (int k = 0; k < 4; k++)
        begin
            c_word.cmd.raddr[k] = {rowsel[k >> 1][YW-1:1], colsel[k & 1][XW-1:1]};
        end
        c_word.cmd.x1p = x1[0];
        c_word.cmd.x2p = x2[0];
        c_word.cmd.y1p = y1[0];
        c_word.cmd.y2p = y2[0];
        c_word.cmd.fx  = b_posx_reg[FRAC-1:0];
        c_word.cmd.fy  = b_posy_reg[FRAC-1:0];
        // drop loads that fall outside the store
        c_word.valid   = b_valid_reg && (b_item_reg.kind == KIND_QUERY || in_range);
    end

    assign push = c_word;

endmodule

@@ rtl/bfs_fifo.sv @@
// Short queue of classified words between front and back.
// Depends on bfs_pkg.
module bfs_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  bfs_pkg::cmd_word_t push,
    output bfs_pkg::cmd_word_t head,
    output logic               busy
);
    import bfs_pkg::*;

    cmd_t              mem [FIFO_DEPTH];
    logic [FPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FCW-1:0]    count_reg, count_next;
    logic              pop;

    assign pop = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + FPW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FPW'(1) : rd_ptr_reg;
        count_next  = count_reg + FCW'(push.valid) - FCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    assign head.valid = pop;
    assign head.cmd   = mem[rd_ptr_reg];
    // hold off new words while the front stages could overrun the queue
    assign busy       = (count_reg > FCW'(FIFO_DEPTH - INFLIGHT - 1));

endmodule

@@ rtl/bfs_back.sv @@
// Back end: four banked source stores, neighbour select and two-pass blend.
// Depends on bfs_pkg.
module bfs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bfs_pkg::cmd_word_t head,
    output logic               valid,
    output bfs_pkg::pix_out_t  result
);
    import bfs_pkg::*;

    logic [23:0]       rd_reg [4];
    logic              d_valid_reg;
    logic              d_x1p_reg, d_x2p_reg, d_y1p_reg, d_y2p_reg;
    logic [FRAC-1:0]   d_fx_reg, d_fy_reg;
    logic              e_valid_reg;
    logic [FRAC-1:0]   e_fy_reg;
    logic [FRAC+7:0]   top_reg [3];
    logic [FRAC+7:0]   bot_reg [3];
    logic              f_valid_reg;
    pix_out_t          f_out_reg;

    logic [23:0]       p11, p21, p12, p22;
    logic [FRAC+7:0]   top_next [3];
    logic [FRAC+7:0]   bot_next [3];
    pix_out_t          f_out_next;
    logic              rd_en;

    assign rd_en = head.valid && !head.cmd.is_load;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [23:0] bank [BANK_DEPTH];
        always_ff @(posedge clk)
        begin
            if (head.valid && head.cmd.is_load && head.cmd.wbank == 2'(k))
            begin
                bank[head.cmd.waddr] <= head.cmd.wdata;
            end
            if (rd_en)
            begin
                rd_reg[k] <= bank[head.cmd.raddr[k]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= rd_en;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_comb
    begin
        p11 = rd_reg[{d_y1p_reg, d_x1p_reg}];
        p21 = rd_reg[{d_y1p_reg, d_x2p_reg}];
        p12 = rd_reg[{d_y2p_reg, d_x1p_reg}];
        p22 = rd_reg[{d_y2p_reg, d_x2p_reg}];
        for (int c = 0; c < 3; c++)
        begin
            top_next[c] = blend_px(d_fx_reg, p11[8*c +: 8], p21[8*c +: 8]);
            bot_next[c] = blend_px(d_fx_reg, p12[8*c +: 8], p22[8*c +: 8]);
        end
        f_out_next.ch0_out = blend_row(e_fy_reg, top_reg[0], bot_reg[0]);
        f_out_next.ch1_out = blend_row(e_fy_reg, top_reg[1], bot_reg[1]);
        f_out_next.ch2_out = blend_row(e_fy_reg, top_reg[2], bot_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        d_x1p_reg <= head.cmd.x1p;
        d_x2p_reg <= head.cmd.x2p;
        d_y1p_reg <= head.cmd.y1p;
        d_y2p_reg <= head.cmd.y2p;
        d_fx_reg  <= head.cmd.fx;
        d_fy_reg  <= head.cmd.fy;
        e_fy_reg  <= d_fy_reg;
        for (int c = 0; c < 3; c++)
        begin
            top_reg[c] <= top_next[c];
            bot_reg[c] <= bot_next[c];
        end
        f_out_reg <= f_out_next;
    end

    assign valid  = f_valid_reg;
    assign result = f_out_reg;

endmodule
